>>> hw/rtl/dcrd_pkg.sv
// Shared types, constants and helpers for the distance-coded reference decoder.
// Used by dcrd_ctrl, dcrd_datapath and distance_coded_reference_decoder.
// Depends on nothing.
`default_nettype none

package dcrd_pkg;

    // Counts per signal period. This must be a power of two; the period count is
    // taken with a plain division by it.
    localparam int unsigned PERIOD_COUNTS = 4;

    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic REG_NOMINAL = 1'b0;
    localparam logic REG_PERIOD  = 1'b1;

    localparam logic [15:0] NOMINAL_RESET = 16'd1000;
    localparam logic [7:0]  PERIOD_RESET  = 8'd20;

    // Command codes. The unused code is handled as a position sample.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_MARK   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Reference modes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_ABS   = 2'd2;

    localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN48 = 64'shFFFF_8000_0000_0000;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] count;
        logic               direction;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] absolute_um;
        logic               position_known;
        logic [1:0]         ref_state;
        logic [31:0]        marks_seen;
        logic signed [47:0] first_mark_um;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic step_mrr;
        logic step_mul1;
        logic step_sum;
        logic step_mul2;
        logic step_offs;
        logic load_out;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       is_mark;
        logic [1:0] mode;
    } ctl_stat_t;

    // Clamp a signed value to the signed 48-bit range.
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > MAX48) begin
            r = MAX48;
        end else if (v < MIN48) begin
            r = MIN48;
        end
        return r[47:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dcrd_ctrl.sv
// Sequencing state machine for the distance-coded reference decoder.
// Drives dcrd_datapath through dcrd_pkg::ctl_cmd_t; uses dcrd_pkg.
`default_nettype none

module dcrd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire dcrd_pkg::ctl_stat_t stat,
    output dcrd_pkg::ctl_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_MRR  = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_MUL2 = 3'd5;
    localparam logic [2:0] ST_OFFS = 3'd6;
    localparam logic [2:0] ST_RESP = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                // Only the second mark needs the long computation.
                if (stat.is_mark && (stat.mode == dcrd_pkg::MODE_FIRST)) begin
                    state_next = ST_MRR;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_MRR:
            begin
                cmd.step_mrr = 1'b1;
                state_next   = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.step_mul1 = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.step_sum = 1'b1;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.step_mul2 = 1'b1;
                state_next    = ST_OFFS;
            end
            ST_OFFS:
            begin
                cmd.step_offs = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP:
            begin
                // The output register may be refilled in the cycle it drains.
                if (!out_valid_reg || !out_stall) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dcrd_datapath.sv
// Datapath of the distance-coded reference decoder: configuration, mark state,
// the first-mark arithmetic and the output register. Uses dcrd_pkg.
`default_nettype none

module dcrd_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic                cfg_index,
    input  wire logic [dcrd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire dcrd_pkg::in_word_t  in_word,
    input  wire dcrd_pkg::ctl_cmd_t  cmd,
    output dcrd_pkg::ctl_stat_t      stat,
    output dcrd_pkg::out_word_t      out_word
);

    // Configuration.
    logic [15:0] nominal_reg;
    logic [7:0]  period_reg;

    // Accepted word.
    logic [1:0]         in_cmd_reg;
    logic signed [31:0] in_cnt_reg;
    logic               in_dir_reg;

    // Architectural state.
    logic [1:0]         mode_reg;
    logic signed [31:0] first_count_reg;
    logic               first_neg_reg;
    logic signed [47:0] first_abs_reg;
    logic signed [47:0] offset_reg;
    logic [31:0]        mark_total_reg;

    // Intermediate results of the second-mark computation.
    logic [32:0]        mrr_reg;
    logic signed [31:0] q_reg;
    logic signed [34:0] t2_reg;
    logic signed [51:0] t1_reg;
    logic signed [51:0] p1_reg;

    dcrd_pkg::out_word_t out_word_reg;

    logic               is_mark;
    logic               is_clear;
    logic signed [32:0] delta;
    logic [32:0]        abs_delta;
    logic [32:0]        mrr_next;
    logic signed [34:0] b_val;
    logic [33:0]        ab_val;
    logic signed [31:0] q_next;
    logic signed [34:0] t2_next;
    logic signed [51:0] p1_next;
    logic signed [8:0]  period_s;
    logic signed [60:0] prod;
    logic               abs_valid;
    dcrd_pkg::out_word_t out_next;

    assign is_mark  = (in_cmd_reg == dcrd_pkg::CMD_MARK);
    assign is_clear = (in_cmd_reg == dcrd_pkg::CMD_CLEAR);

    assign stat.is_mark = is_mark;
    assign stat.mode    = mode_reg;

    always_comb
    begin
        delta     = 33'(in_cnt_reg) - 33'(first_count_reg);
        abs_delta = delta[32] ? 33'(-delta) : 33'(delta);
        mrr_next  = 33'(abs_delta / dcrd_pkg::PERIOD_COUNTS);
    end

    // B = 2*MRR - N; the half term and the direction term of P1.
    always_comb
    begin
        b_val  = signed'({1'b0, mrr_reg, 1'b0}) - signed'({19'd0, nominal_reg});
        ab_val = b_val[34] ? 34'(-b_val) : 34'(b_val);
        if (b_val[34]) begin
            q_next = 32'(ab_val >> 1);
        end else if (ab_val == 34'd0) begin
            // With B exactly zero the half term truncates to minus one.
            q_next = -32'sd1;
        end else if (ab_val == 34'd1) begin
            q_next = '0;
        end else begin
            q_next = 32'((ab_val - 34'd2) >> 1);
        end
        if (!b_val[34] && first_neg_reg) begin
            t2_next = signed'({2'b00, mrr_reg});
        end else if (b_val[34] && !first_neg_reg) begin
            t2_next = -signed'({2'b00, mrr_reg});
        end else begin
            t2_next = '0;
        end
    end

    always_comb
    begin
        p1_next  = t1_reg + 52'(t2_reg);
        period_s = signed'({1'b0, period_reg});
        prod     = p1_reg * period_s;
    end

    always_comb
    begin
        abs_valid                   = (mode_reg == dcrd_pkg::MODE_ABS);
        out_next.position_known     = abs_valid;
        out_next.ref_state          = mode_reg;
        out_next.marks_seen         = mark_total_reg;
        out_next.first_mark_um      = first_abs_reg;
        if (abs_valid) begin
            out_next.absolute_um = dcrd_pkg::sat48(64'(in_cnt_reg) + 64'(offset_reg));
        end else begin
            out_next.absolute_um = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            nominal_reg <= dcrd_pkg::NOMINAL_RESET;
            period_reg  <= dcrd_pkg::PERIOD_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                dcrd_pkg::REG_NOMINAL: nominal_reg <= cfg_data[15:0];
                dcrd_pkg::REG_PERIOD:  period_reg  <= cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg        <= dcrd_pkg::MODE_IDLE;
            first_count_reg <= '0;
            first_neg_reg   <= 1'b0;
            first_abs_reg   <= '0;
            offset_reg      <= '0;
            mark_total_reg  <= '0;
        end else if (cmd.exec) begin
            if (is_clear) begin
                mode_reg        <= dcrd_pkg::MODE_IDLE;
                first_count_reg <= '0;
                first_neg_reg   <= 1'b0;
                first_abs_reg   <= '0;
                offset_reg      <= '0;
                mark_total_reg  <= '0;
            end else if (is_mark) begin
                mark_total_reg <= mark_total_reg + 32'd1;
                if (mode_reg == dcrd_pkg::MODE_IDLE) begin
                    first_count_reg <= in_cnt_reg;
                    first_neg_reg   <= in_dir_reg;
                    mode_reg        <= dcrd_pkg::MODE_FIRST;
                end
            end
        end else if (cmd.step_mul2) begin
            first_abs_reg <= dcrd_pkg::sat48(64'(prod));
        end else if (cmd.step_offs) begin
            offset_reg <= dcrd_pkg::sat48(64'(first_abs_reg) - 64'(first_count_reg));
            mode_reg   <= dcrd_pkg::MODE_ABS;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in) begin
            in_cmd_reg <= in_word.command;
            in_cnt_reg <= in_word.count;
            in_dir_reg <= in_word.direction;
        end
        if (cmd.exec) begin
            mrr_reg <= mrr_next;
        end
        if (cmd.step_mrr) begin
            q_reg  <= q_next;
            t2_reg <= t2_next;
        end
        if (cmd.step_mul1) begin
            t1_reg <= q_reg * signed'({1'b0, nominal_reg});
        end
        if (cmd.step_sum) begin
            p1_reg <= p1_next;
        end
        if (cmd.load_out) begin
            out_word_reg <= out_next;
        end
    end

    assign out_word = out_word_reg;

endmodule

`default_nettype wire

>>> hw/rtl/distance_coded_reference_decoder.sv
// Top level of the distance-coded reference decoder.
// Joins dcrd_ctrl and dcrd_datapath; uses dcrd_pkg.
//
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall   dcrd_pkg::in_word_t
// output    out        out_valid / out_stall dcrd_pkg::out_word_t
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample, a clear or a first mark passes the execute and response states before
// the next word is taken; the second mark also steps the half and direction terms,
// two registered multiplies, a sum and the offset subtract.
// Reset clears all mark state and loads the register defaults; no sweep.
// A waiting result sits in the output register while the next word is taken.
// Configuration writes are always accepted.
`default_nettype none

module distance_coded_reference_decoder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire dcrd_pkg::in_word_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output dcrd_pkg::out_word_t      out_word,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [dcrd_pkg::CFG_DATA_W-1:0] cfg_data
);

    dcrd_pkg::ctl_cmd_t  cmd;
    dcrd_pkg::ctl_stat_t stat;

    assign cfg_ready = 1'b1;

    dcrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    dcrd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for distance_coded_reference_decoder.
// Drives command words through a directed table and random mark sequences, and
// checks each result against a built-in model or a pinned row; uses dcrd_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] CMD_SPARE      = 2'd3;
    localparam int         SETTLE_CYCLES  = 12;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         REPORT_LIMIT   = 10;
    localparam longint     COUNT_MAX      = 64'sd2147483647;
    localparam longint     COUNT_MIN      = -64'sd2147483648;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    dcrd_pkg::in_word_t  in_word = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    dcrd_pkg::out_word_t out_word;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = dcrd_pkg::REG_NOMINAL;
    logic [15:0]         cfg_data = '0;

    distance_coded_reference_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Decoder state as the block should hold it.
    logic [15:0] nominal_n = dcrd_pkg::NOMINAL_RESET;
    logic [7:0]  period_um = dcrd_pkg::PERIOD_RESET;
    logic [1:0]  mode = dcrd_pkg::MODE_IDLE;
    longint      first_cnt = 0;
    logic        first_neg = 1'b0;
    longint      first_abs = 0;
    longint      offset_um = 0;
    logic [31:0] mark_count = '0;

    dcrd_pkg::out_word_t predicted_words [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    logic        no_idle = 1'b0;

    // Pinned rows carry a result that can be read straight off the command
    // history; the others are left to the model.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] cnt;
        logic        dir;
        logic        pinned;
        logic [1:0]  st;
        logic [31:0] marks;
    } stim_row_t;

    stim_row_t directed_rows [24] = '{
        '{dcrd_pkg::CMD_SAMPLE, 32'h0000_0000, 1'b0, 1'b1, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1, dcrd_pkg::MODE_IDLE,  32'd0},
        '{CMD_SPARE,            32'h8000_0000, 1'b0, 1'b1, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_MARK,   32'h0000_0064, 1'b0, 1'b1, dcrd_pkg::MODE_FIRST, 32'd1},
        '{dcrd_pkg::CMD_SAMPLE, 32'hFFFF_FFFB, 1'b1, 1'b1, dcrd_pkg::MODE_FIRST, 32'd1},
        '{dcrd_pkg::CMD_MARK,   32'hFFFF_F86C, 1'b1, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_SAMPLE, 32'h0000_0000, 1'b0, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_MARK,   32'h0000_0007, 1'b0, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_SAMPLE, 32'h8000_0000, 1'b1, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_CLEAR,  32'h0000_0000, 1'b0, 1'b1, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_MARK,   32'h8000_0000, 1'b1, 1'b1, dcrd_pkg::MODE_FIRST, 32'd1},
        '{dcrd_pkg::CMD_MARK,   32'h7FFF_FFFF, 1'b0, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 1'b1, 1'b1, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_MARK,   32'h0000_0000, 1'b0, 1'b1, dcrd_pkg::MODE_FIRST, 32'd1},
        '{dcrd_pkg::CMD_MARK,   32'h0000_0000, 1'b1, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_CLEAR,  32'h0000_0000, 1'b0, 1'b1, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_MARK,   32'h0000_0005, 1'b1, 1'b1, dcrd_pkg::MODE_FIRST, 32'd1},
        '{dcrd_pkg::CMD_MARK,   32'h0000_07D5, 1'b0, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_SAMPLE, 32'h1234_5678, 1'b0, 1'b0, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_CLEAR,  32'hAAAA_AAAA, 1'b0, 1'b1, dcrd_pkg::MODE_IDLE,  32'd0},
        '{dcrd_pkg::CMD_SAMPLE, 32'h5555_5555, 1'b1, 1'b1, dcrd_pkg::MODE_IDLE,  32'd0}
    };

    function automatic longint clamp48(input longint v);
        longint hi;
        longint lo;
        hi = 64'sh0000_7FFF_FFFF_FFFF;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // The first mark's position in signal periods, from the mark distance
    // and the direction in which the first mark was crossed.
    function automatic longint first_mark_periods(input longint mrr);
        longint n;
        longint b;
        longint sb;
        longint sd;
        longint ab;
        n  = nominal_n;
        b  = 2 * mrr - n;
        sb = (b >= 0) ? 1 : -1;
        sd = first_neg ? -1 : 1;
        ab = (b >= 0) ? b : -b;
        return ((ab - sb - 1) / 2) * n + ((sb - sd) / 2) * mrr;
    endfunction

    function automatic dcrd_pkg::out_word_t decode_word(input dcrd_pkg::in_word_t w);
        dcrd_pkg::out_word_t r;
        longint    cnt;
        longint    delta;
        longint    abs_um;
        longint    period;
        cnt    = $signed(w.count);
        abs_um = 0;
        period = period_um;
        case (w.command)
            dcrd_pkg::CMD_CLEAR:
            begin
                mode       = dcrd_pkg::MODE_IDLE;
                first_cnt  = 0;
                first_neg  = 1'b0;
                first_abs  = 0;
                offset_um  = 0;
                mark_count = '0;
            end
            dcrd_pkg::CMD_MARK:
            begin
                mark_count = mark_count + 32'd1;
                if (mode == dcrd_pkg::MODE_IDLE)
                begin
                    first_cnt = cnt;
                    first_neg = w.direction;
                    mode      = dcrd_pkg::MODE_FIRST;
                end
                else if (mode == dcrd_pkg::MODE_FIRST)
                begin
                    delta     = cnt - first_cnt;
                    if (delta < 0)
                    begin
                        delta = -delta;
                    end
                    first_abs = clamp48(
                        first_mark_periods(delta / dcrd_pkg::PERIOD_COUNTS) * period);
                    offset_um = clamp48(first_abs - first_cnt);
                    mode      = dcrd_pkg::MODE_ABS;
                end
            end
            default:
            begin
            end
        endcase
        if (mode == dcrd_pkg::MODE_ABS)
        begin
            abs_um = clamp48(cnt + offset_um);
        end
        r.absolute_um    = abs_um[47:0];
        r.position_known = (mode == dcrd_pkg::MODE_ABS);
        r.ref_state      = mode;
        r.marks_seen     = mark_count;
        r.first_mark_um  = first_abs[47:0];
        return r;
    endfunction

    task automatic report_error(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    task automatic check_word(input dcrd_pkg::out_word_t got);
        dcrd_pkg::out_word_t want;
        if (predicted_words.size() == 0)
        begin
            report_error("result word with nothing expected", '0, got.absolute_um);
            return;
        end
        want = predicted_words.pop_front();
        if (got.absolute_um !== want.absolute_um)
        begin
            report_error("absolute_um", want.absolute_um, got.absolute_um);
        end
        if (got.position_known !== want.position_known)
        begin
            report_error("position_known", want.position_known, got.position_known);
        end
        if (got.ref_state !== want.ref_state)
        begin
            report_error("ref_state", want.ref_state, got.ref_state);
        end
        if (got.marks_seen !== want.marks_seen)
        begin
            report_error("marks_seen", want.marks_seen, got.marks_seen);
        end
        if (got.first_mark_um !== want.first_mark_um)
        begin
            report_error("first_mark_um", want.first_mark_um, got.first_mark_um);
        end
    endtask

    // Result side: check accepted words, then pick the next stall value.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_word(out_word);
        end
        out_stall <= !no_idle && ($urandom_range(99) < 24);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Returns at the edge that takes the word, with in_valid still high; the
    // caller either sends again or lowers in_valid in that same step.
    task automatic send_word(input dcrd_pkg::in_word_t w, input logic pinned,
                             input dcrd_pkg::out_word_t pinned_word);
        dcrd_pkg::out_word_t predicted;
        while (!no_idle && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        predicted = decode_word(w);
        predicted_words.push_back(pinned ? pinned_word : predicted);
    endtask

    task automatic send_fields(input logic [1:0] cmd, input logic [31:0] cnt, input logic dir);
        dcrd_pkg::in_word_t w;
        w.command   = cmd;
        w.count     = cnt;
        w.direction = dir;
        send_word(w, 1'b0, '0);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        while (predicted_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == dcrd_pkg::REG_NOMINAL)
        begin
            nominal_n = data;
        end
        else
        begin
            period_um = data[7:0];
        end
    endtask

    task automatic configure(input logic [15:0] n, input logic [7:0] period);
        write_reg(dcrd_pkg::REG_NOMINAL, n);
        write_reg(dcrd_pkg::REG_PERIOD, {8'($urandom), period});
    endtask

    // Usually a clear, then a first mark, a second mark at a chosen period distance, and
    // samples around them; sometimes a further mark that only gets counted.
    task automatic mark_sequence();
        longint first;
        longint second;
        longint span;
        if ($urandom_range(9) < 7)
        begin
            send_fields(dcrd_pkg::CMD_CLEAR, $urandom, 1'($urandom));
        end
        if ($urandom_range(1))
        begin
            first = $signed(32'($urandom));
        end
        else
        begin
            first = longint'($urandom_range(0, 20000)) - 10000;
        end
        send_fields(dcrd_pkg::CMD_MARK, first[31:0], 1'($urandom));
        repeat ($urandom_range(0, 3)) send_fields(dcrd_pkg::CMD_SAMPLE, $urandom, 1'($urandom));
        if ($urandom_range(9) < 7)
        begin
            span = longint'($urandom_range(0, 2 * int'(nominal_n) + 2));
        end
        else
        begin
            span = longint'($urandom_range(0, 32'h3FFF_FFFF));
        end
        span = span * dcrd_pkg::PERIOD_COUNTS + longint'($urandom_range(0, 3));
        if ($urandom_range(1))
        begin
            span = -span;
        end
        second = first + span;
        if (second > COUNT_MAX || second < COUNT_MIN)
        begin
            second = first - span;
        end
        if (second > COUNT_MAX || second < COUNT_MIN)
        begin
            second = $signed(32'($urandom));
        end
        send_fields(dcrd_pkg::CMD_MARK, second[31:0], 1'($urandom));
        repeat ($urandom_range(1, 5)) send_fields(dcrd_pkg::CMD_SAMPLE, $urandom, 1'($urandom));
        if ($urandom_range(3) == 0)
        begin
            send_fields(dcrd_pkg::CMD_MARK, $urandom, 1'($urandom));
            send_fields(dcrd_pkg::CMD_SAMPLE, $urandom, 1'($urandom));
        end
    endtask

    task automatic random_phase(input int words);
        repeat (words / 8)
        begin
            if ($urandom_range(99) < 85)
            begin
                mark_sequence();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_fields(2'($urandom_range(0, 3)), $urandom, 1'($urandom));
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        stim_row_t           row;
        dcrd_pkg::in_word_t  w;
        dcrd_pkg::out_word_t pinned_word;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row                          = directed_rows[i];
            w.command                    = row.cmd;
            w.count                      = row.cnt;
            w.direction                  = row.dir;
            pinned_word                  = '0;
            pinned_word.ref_state        = row.st;
            pinned_word.marks_seen       = row.marks;
            send_word(w, row.pinned, pinned_word);
        end
        in_valid <= 1'b0;

        random_phase(170);
        configure(16'hFFFF, 8'hFF);
        random_phase(170);
        configure(16'h0000, 8'h00);
        random_phase(150);
        configure(16'h0001, 8'h01);
        random_phase(150);
        configure(16'($urandom), 8'($urandom));
        no_idle = 1'b1;
        random_phase(180);
        no_idle = 1'b0;
        configure(dcrd_pkg::NOMINAL_RESET, dcrd_pkg::PERIOD_RESET);
        random_phase(180);

        while (predicted_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> distance_coded_reference_decoder.f
hw/rtl/dcrd_pkg.sv
hw/rtl/dcrd_ctrl.sv
hw/rtl/dcrd_datapath.sv
hw/rtl/distance_coded_reference_decoder.sv
tb/sv/testbench.sv
